// ----- src/lps_pkg.sv -----
package lps_pkg;

  localparam int unsigned WordW = 31;
  localparam int unsigned ProdW = 2 * WordW;
  localparam int unsigned AddrW = 3;
  localparam int unsigned PDataW = 32;

  typedef logic [WordW-1:0] word_t;
  typedef logic [ProdW-1:0] prod_t;

  localparam word_t LcgMod    = 31'h7FFF_FFFF;
  localparam word_t LcgMult   = 31'd16807;
  localparam word_t SeedReset = 31'd1;

  // register index taken from paddr above the byte offset
  localparam logic RegSeed = 1'b0;

  typedef struct packed {
    logic mul_step;
    logic reduce;
    logic mul_scale;
    logic load_out;
  } dp_cmd_t;

endpackage

// ----- src/lps_if.sv -----
interface lps_req_if;
  import lps_pkg::*;

  logic  valid;
  logic  ready;
  word_t bound;

  modport source (output valid, output bound, input ready);
  modport sink (input valid, input bound, output ready);
endinterface

interface lps_rsp_if;
  import lps_pkg::*;

  logic  valid;
  logic  ready;
  word_t raw_state;
  word_t scaled_value;
  logic  coin;

  modport source (output valid, output raw_state, output scaled_value, output coin,
                  input ready);
  modport sink (input valid, input raw_state, input scaled_value, input coin,
                output ready);
endinterface

// ----- src/lps_ctrl.sv -----
module lps_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output lps_pkg::dp_cmd_t cmd_o
);
  import lps_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RED  = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_DIV  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    out_valid_d    = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.mul_step = 1'b1;
          state_d        = ST_RED;
        end
      end
      ST_RED: begin
        cmd_o.reduce = 1'b1;
        state_d      = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_scale = 1'b1;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        // hold the quotient until the output register is free
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_cmd_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.mul_step, cmd_o.reduce, cmd_o.mul_scale, cmd_o.load_out}))
    else $error("more than one datapath command");

  a_accept_red: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_RED))
    else $error("accepted item did not enter reduction");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> out_valid_q)
    else $error("output load lost");

  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) && out_valid_q && !out_ready_i |=> (state_q == ST_DIV))
    else $error("result overwrote a pending transfer");

endmodule

// ----- src/lps_dpath.sv -----
module lps_dpath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lps_pkg::dp_cmd_t cmd_i,
  input  logic             seed_we_i,
  input  lps_pkg::word_t   seed_i,
  input  lps_pkg::word_t   bound_i,
  output lps_pkg::word_t   raw_state_o,
  output lps_pkg::word_t   scaled_value_o,
  output logic             coin_o
);
  import lps_pkg::*;

  word_t       state_q, state_d;
  word_t       bound_q;
  prod_t       prod_q;
  word_t       raw_q, scaled_q;
  logic        coin_q;

  word_t       mul_b;
  prod_t       mul_res;
  word_t       seed_fix;
  logic [31:0] fold_sum, fold_res;
  logic [31:0] r1, rem;
  logic        q1, adj;
  word_t       quot;

  // shared multiplier: 16807 * state, then new state * bound
  assign mul_b   = cmd_i.mul_scale ? bound_q : LcgMult;
  assign mul_res = ProdW'(state_q) * ProdW'(mul_b);

  // 2^31 == 1 mod M, so fold the high part onto the low part
  assign fold_sum = {1'b0, prod_q[WordW-1:0]} + 32'(prod_q[45:WordW]);
  assign fold_res = (fold_sum >= {1'b0, LcgMod}) ? fold_sum - {1'b0, LcgMod} : fold_sum;

  // floor(p / M): p = q0*M + (q0 + r0), then at most two small corrections
  assign r1   = {1'b0, prod_q[ProdW-1:WordW]} + {1'b0, prod_q[WordW-1:0]};
  assign q1   = r1[31];
  assign rem  = {1'b0, r1[WordW-1:0]} + 32'(q1);
  assign adj  = (rem >= {1'b0, LcgMod});
  assign quot = prod_q[ProdW-1:WordW] + WordW'(q1) + WordW'(adj);

  // zero and M lock the generator, load 1 instead
  assign seed_fix = ((seed_i == '0) || (seed_i == LcgMod)) ? SeedReset : seed_i;

  always_comb begin
    state_d = state_q;
    priority if (seed_we_i) begin
      state_d = seed_fix;
    end else if (cmd_i.reduce) begin
      state_d = fold_res[WordW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SeedReset;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_step) begin
      bound_q <= bound_i;
    end
    if (cmd_i.mul_step || cmd_i.mul_scale) begin
      prod_q <= mul_res;
    end
    if (cmd_i.load_out) begin
      raw_q    <= state_q;
      scaled_q <= quot;
      // 2*s < M exactly when s < 2^30
      coin_q   <= ~state_q[WordW-1];
    end
  end

  assign raw_state_o    = raw_q;
  assign scaled_value_o = scaled_q;
  assign coin_o         = coin_q;

endmodule

// ----- src/lehmer_prng_with_scaling.sv -----
// channel   dir  modport  transfer when     payload
// req_i     in   sink     valid && ready    bound
// rsp_o     out  source   valid && ready    raw_state, scaled_value, coin
// apb       in   slave    psel&penable&pwrite  seed_value at byte address 0
//
// an item goes through the steps accept, reduce, scale multiply, divide by M;
// the single 31x31 multiplier is used twice and each product is registered
// the result sits in an output register; the next request is taken once it loads
// a stalled output holds the block in the divide step until the transfer completes
// reset loads the state and the seed register with 1
module lehmer_prng_with_scaling (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  lps_req_if.sink                    req_i,
  lps_rsp_if.source                  rsp_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lps_pkg::AddrW-1:0]  paddr,
  input  logic [lps_pkg::PDataW-1:0] pwdata,
  output logic [lps_pkg::PDataW-1:0] prdata,
  output logic                       pready
);
  import lps_pkg::*;

  dp_cmd_t cmd;
  logic    seed_we;
  word_t   seed_q;

  assign pready  = 1'b1;
  assign seed_we = psel && penable && pwrite && (paddr[AddrW-1] == RegSeed);
  assign prdata  = (paddr[AddrW-1] == RegSeed) ? {1'b0, seed_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SeedReset;
    end else if (seed_we) begin
      seed_q <= pwdata[WordW-1:0];
    end
  end

  lps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  lps_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .seed_we_i      (seed_we),
    .seed_i         (pwdata[WordW-1:0]),
    .bound_i        (req_i.bound),
    .raw_state_o    (rsp_o.raw_state),
    .scaled_value_o (rsp_o.scaled_value),
    .coin_o         (rsp_o.coin)
  );

endmodule
